[design/c2t_pkg.sv]
// Shared types and constants for the C-aware space-to-tab converter.
package c2t_pkg;

  // Default configuration of the converter
  localparam int TabWidthDef   = 8;
  localparam int MaxColumnsDef = 256;

  // Results one input item may cause at most
  localparam int ResultLimit = 40;
  localparam int CntW        = $clog2(ResultLimit);

  // Configuration port geometry
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // Character codes
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;

  // Operation of the shared column unit
  typedef enum logic {
    OP_INC,
    OP_TAB
  } col_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH_CHK,
    ST_FLUSH_TAB,
    ST_FLUSH_SPACE,
    ST_EMIT
  } seq_state_e;

endpackage

[design/c_aware_space_to_tab_converter_top.sv]
// Top level of the C-aware space-to-tab converter: register port and sequencer.
//
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_stall_o    in_char_i, end_of_line_i
//  output    out        out_valid_o / out_stall_i  out_char_o, out_end_of_line_o, last_o
//  config    in/out     psel, penable, pwrite      paddr, pwdata, prdata
//
// An item is captured while idle and decided in the next; a gathered blank, an end
// of line or a pass-through item then goes back to idle, a plain character to emit. A
// character after a run passes flush check, tab flush once tabs are tried, space flush
// and emit: one column unit steps the run one emitted tab or space per unstalled cycle.
// Reset leaves column 1, no run, no quote or comment, conversion disabled.
// A stalled output holds the sequencer; the input is stalled while an item is in work.
module c_aware_space_to_tab_converter_top #(
  parameter int TAB_WIDTH   = c2t_pkg::TabWidthDef,
  parameter int MAX_COLUMNS = c2t_pkg::MaxColumnsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [c2t_pkg::AddrW-1:0] paddr,
  input  logic [c2t_pkg::DataW-1:0] pwdata,
  output logic [c2t_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                in_char_i,
  input  logic                      end_of_line_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_char_o,
  output logic                      out_end_of_line_o,
  output logic                      last_o
);

  logic enable_q;
  logic reg_sel;

  // Register 0 sits at byte address 0; the upper address bit selects beyond it
  assign reg_sel = (paddr[c2t_pkg::AddrW-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(c2t_pkg::DataW-1){1'b0}}, enable_q} : '0;

  // Write the enable register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      enable_q <= pwdata[0];
    end
  end

  c2t_seq #(
    .TAB_WIDTH  (TAB_WIDTH),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .enable_i         (enable_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .end_of_line_i    (end_of_line_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_end_of_line_o(out_end_of_line_o),
    .last_o           (last_o)
  );

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // An end-of-line result is always the sole, final result with no character
  a_eol_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_of_line_o |-> last_o && (out_char_o == 8'h00))
    else $error("malformed end-of-line result");

  // Results ahead of the final one are rewritten run blanks only
  a_run_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !out_end_of_line_o &&
      ((out_char_o == c2t_pkg::ChTab) || (out_char_o == c2t_pkg::ChSpace)))
    else $error("non-final result is not a tab or space");

endmodule

[design/c2t_col_unit.sv]
// Shared column unit: step a column by one or to the next tab stop, compare to a bound.
module c2t_col_unit #(
  parameter int TAB_WIDTH   = c2t_pkg::TabWidthDef,
  parameter int MAX_COLUMNS = c2t_pkg::MaxColumnsDef,
  localparam int ColW = $clog2(MAX_COLUMNS + 1),
  localparam int PhW  = $clog2(TAB_WIDTH)
) (
  input  c2t_pkg::col_op_e op_i,
  input  logic [ColW-1:0]  col_i,
  input  logic [PhW-1:0]   phase_i,
  input  logic [ColW-1:0]  bound_i,
  output logic [ColW-1:0]  col_o,
  output logic [PhW-1:0]   phase_o,
  output logic             fits_o,
  output logic             below_o
);

  localparam logic [ColW:0]  MaxU     = (ColW+1)'(MAX_COLUMNS);
  localparam logic [ColW:0]  TabU     = (ColW+1)'(TAB_WIDTH);
  localparam logic [PhW-1:0] SatPhase = PhW'((MAX_COLUMNS - 1) % TAB_WIDTH);
  localparam logic [PhW-1:0] LastPh   = PhW'(TAB_WIDTH - 1);

  logic [ColW:0]  step;
  logic [ColW:0]  nxt_unsat;
  logic [PhW-1:0] nxt_phase;

  // Distance to the next stop is the tab width less the phase within the tab
  always_comb begin
    if (op_i == c2t_pkg::OP_TAB) begin
      step      = TabU - (ColW+1)'(phase_i);
      nxt_phase = '0;
    end else begin
      step      = (ColW+1)'(1);
      nxt_phase = (phase_i == LastPh) ? '0 : phase_i + PhW'(1);
    end
    nxt_unsat = {1'b0, col_i} + step;
  end

  // Saturate at the last column and compare the raw sum with the bound
  always_comb begin
    if (nxt_unsat > MaxU) begin
      col_o   = ColW'(MAX_COLUMNS);
      phase_o = SatPhase;
    end else begin
      col_o   = nxt_unsat[ColW-1:0];
      phase_o = nxt_phase;
    end
    fits_o  = nxt_unsat <= {1'b0, bound_i};
    below_o = nxt_unsat <  {1'b0, bound_i};
  end

endmodule

[design/c2t_seq.sv]
// Sequencer: lexer state, run tracking, run rewrite and result register.
module c2t_seq #(
  parameter int TAB_WIDTH   = c2t_pkg::TabWidthDef,
  parameter int MAX_COLUMNS = c2t_pkg::MaxColumnsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       enable_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_end_of_line_o,
  output logic       last_o
);

  localparam int ColW = $clog2(MAX_COLUMNS + 1);
  localparam int PhW  = $clog2(TAB_WIDTH);

  c2t_pkg::seq_state_e state_q, state_d;

  logic [7:0]            item_char_q;
  logic                  item_eol_q;
  logic [ColW-1:0]       column_q, column_d;
  logic [PhW-1:0]        col_ph_q, col_ph_d;
  logic [ColW-1:0]       run_end_q, run_end_d;
  logic [PhW-1:0]        run_ph_q, run_ph_d;
  logic                  run_pending_q, run_pending_d;
  logic                  sq_q, sq_d;
  logic                  dq_q, dq_d;
  logic                  cmt_q, cmt_d;
  logic                  esc_q, esc_d;
  logic                  pslash_q, pslash_d;
  logic                  pstar_q, pstar_d;
  logic                  tabs_ok_q, tabs_ok_d;
  logic [c2t_pkg::CntW-1:0] cnt_q, cnt_d;

  logic       out_valid_q;
  logic [7:0] out_char_q, out_char_d;
  logic       out_eol_q, out_eol_d;
  logic       out_last_q, out_last_d;
  logic       load;

  c2t_pkg::col_op_e u_op;
  logic [ColW-1:0]  u_col, u_col_nxt;
  logic [PhW-1:0]   u_ph, u_ph_nxt;
  logic             u_fits, u_below;

  logic in_take, out_free, quoted, is_blank, emit_ok;
  logic op_by_char;

  assign in_stall_o = (state_q != c2t_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign quoted     = sq_q || dq_q;
  assign is_blank   = (item_char_q == c2t_pkg::ChSpace) || (item_char_q == c2t_pkg::ChTab);
  assign emit_ok    = cnt_q < c2t_pkg::CntW'(c2t_pkg::ResultLimit - 1);
  assign op_by_char = (item_char_q == c2t_pkg::ChTab);

  // Pick the operand and operation of the column unit for this state
  always_comb begin
    u_col = column_q;
    u_ph  = col_ph_q;
    u_op  = c2t_pkg::OP_INC;
    case (state_q)
      c2t_pkg::ST_DECIDE: begin
        if (run_pending_q) begin
          u_col = run_end_q;
          u_ph  = run_ph_q;
        end
        u_op = op_by_char ? c2t_pkg::OP_TAB : c2t_pkg::OP_INC;
      end
      c2t_pkg::ST_FLUSH_TAB: u_op = c2t_pkg::OP_TAB;
      c2t_pkg::ST_EMIT:      u_op = op_by_char ? c2t_pkg::OP_TAB : c2t_pkg::OP_INC;
      default:               u_op = c2t_pkg::OP_INC;
    endcase
  end

  c2t_col_unit #(
    .TAB_WIDTH  (TAB_WIDTH),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_col_unit (
    .op_i   (u_op),
    .col_i  (u_col),
    .phase_i(u_ph),
    .bound_i(run_end_q),
    .col_o  (u_col_nxt),
    .phase_o(u_ph_nxt),
    .fits_o (u_fits),
    .below_o(u_below)
  );

  // Next state, lexer updates and result loading
  always_comb begin
    state_d       = state_q;
    column_d      = column_q;
    col_ph_d      = col_ph_q;
    run_end_d     = run_end_q;
    run_ph_d      = run_ph_q;
    run_pending_d = run_pending_q;
    sq_d          = sq_q;
    dq_d          = dq_q;
    cmt_d         = cmt_q;
    esc_d         = esc_q;
    pslash_d      = pslash_q;
    pstar_d       = pstar_q;
    tabs_ok_d     = tabs_ok_q;
    cnt_d         = cnt_q;
    load          = 1'b0;
    out_char_d    = item_char_q;
    out_eol_d     = 1'b0;
    out_last_d    = 1'b1;

    case (state_q)
      c2t_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_take) begin
          state_d = c2t_pkg::ST_DECIDE;
        end
      end

      c2t_pkg::ST_DECIDE: begin
        if (!enable_i) begin
          // Pass the item through untouched
          out_char_d = item_eol_q ? 8'h00 : item_char_q;
          out_eol_d  = item_eol_q;
          if (out_free) begin
            load    = 1'b1;
            state_d = c2t_pkg::ST_IDLE;
          end
        end else if (item_eol_q) begin
          // Drop any run, clear line-local marks, emit the marker
          out_char_d = 8'h00;
          out_eol_d  = 1'b1;
          if (out_free) begin
            load          = 1'b1;
            run_pending_d = 1'b0;
            esc_d         = 1'b0;
            pslash_d      = 1'b0;
            pstar_d       = 1'b0;
            column_d      = ColW'(1);
            col_ph_d      = '0;
            run_end_d     = ColW'(1);
            run_ph_d      = '0;
            state_d       = c2t_pkg::ST_IDLE;
          end
        end else if (!esc_q && !quoted && is_blank) begin
          // Gather the blank into the pending run
          run_pending_d = 1'b1;
          run_end_d     = u_col_nxt;
          run_ph_d      = u_ph_nxt;
          pslash_d      = 1'b0;
          pstar_d       = 1'b0;
          state_d       = c2t_pkg::ST_IDLE;
        end else if (run_pending_q) begin
          state_d = c2t_pkg::ST_FLUSH_CHK;
        end else begin
          state_d = c2t_pkg::ST_EMIT;
        end
      end

      c2t_pkg::ST_FLUSH_CHK: begin
        // Tabs only when the run reaches past the next column
        tabs_ok_d = u_below;
        state_d   = u_below ? c2t_pkg::ST_FLUSH_TAB : c2t_pkg::ST_FLUSH_SPACE;
      end

      c2t_pkg::ST_FLUSH_TAB: begin
        out_char_d = c2t_pkg::ChTab;
        out_last_d = 1'b0;
        if (!tabs_ok_q || !u_fits) begin
          state_d = c2t_pkg::ST_FLUSH_SPACE;
        end else if (!emit_ok || out_free) begin
          load     = emit_ok;
          cnt_d    = emit_ok ? cnt_q + c2t_pkg::CntW'(1) : cnt_q;
          column_d = u_col_nxt;
          col_ph_d = u_ph_nxt;
        end
      end

      c2t_pkg::ST_FLUSH_SPACE: begin
        out_char_d = c2t_pkg::ChSpace;
        out_last_d = 1'b0;
        if (!u_fits) begin
          run_pending_d = 1'b0;
          state_d       = c2t_pkg::ST_EMIT;
        end else if (!emit_ok || out_free) begin
          load     = emit_ok;
          cnt_d    = emit_ok ? cnt_q + c2t_pkg::CntW'(1) : cnt_q;
          column_d = u_col_nxt;
          col_ph_d = u_ph_nxt;
        end
      end

      c2t_pkg::ST_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          column_d = u_col_nxt;
          col_ph_d = u_ph_nxt;
          pslash_d = 1'b0;
          pstar_d  = 1'b0;
          state_d  = c2t_pkg::ST_IDLE;
          // Track escape, quote and comment state
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (item_char_q == c2t_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else if (item_char_q == c2t_pkg::ChDquote) begin
            if (!cmt_q && !sq_q) dq_d = !dq_q;
          end else if (item_char_q == c2t_pkg::ChSquote) begin
            if (!cmt_q && !dq_q) sq_d = !sq_q;
          end else if (item_char_q == c2t_pkg::ChStar) begin
            if (pslash_q && !quoted && !cmt_q) cmt_d = 1'b1;
            else pstar_d = 1'b1;
          end else if (item_char_q == c2t_pkg::ChSlash) begin
            if (pstar_q && !quoted && cmt_q) cmt_d = 1'b0;
            else pslash_d = 1'b1;
          end
        end
      end

      default: state_d = c2t_pkg::ST_IDLE;
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c2t_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold column, run and lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= ColW'(1);
      col_ph_q      <= '0;
      run_end_q     <= ColW'(1);
      run_ph_q      <= '0;
      run_pending_q <= 1'b0;
      sq_q          <= 1'b0;
      dq_q          <= 1'b0;
      cmt_q         <= 1'b0;
      esc_q         <= 1'b0;
      pslash_q      <= 1'b0;
      pstar_q       <= 1'b0;
      tabs_ok_q     <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      column_q      <= column_d;
      col_ph_q      <= col_ph_d;
      run_end_q     <= run_end_d;
      run_ph_q      <= run_ph_d;
      run_pending_q <= run_pending_d;
      sq_q          <= sq_d;
      dq_q          <= dq_d;
      cmt_q         <= cmt_d;
      esc_q         <= esc_d;
      pslash_q      <= pslash_d;
      pstar_q       <= pstar_d;
      tabs_ok_q     <= tabs_ok_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= load || (out_valid_q && out_stall_i);
    end
  end

  // Capture the input item and the result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_char_q <= in_char_i;
      item_eol_q  <= end_of_line_i;
    end
    if (load) begin
      out_char_q <= out_char_d;
      out_eol_q  <= out_eol_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_char_o        = out_char_q;
  assign out_end_of_line_o = out_eol_q;
  assign last_o            = out_last_q;

endmodule
